### src/bsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared widths, types and Booth recoding codes for the radix-2 Booth
// signed multiplier pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int WIDTH     = 32;            // operand width, 2 .. 32
    localparam int ACC_W     = WIDTH + 1;     // accumulator with one guard bit
    localparam int FIELD_W   = 32;            // width of each input field
    localparam int PRODUCT_W = 64;            // width of the product field
    localparam int IN_DATA_W = 2 * FIELD_W;
    localparam int STAGES    = WIDTH;         // one Booth step per stage

    // Booth pair {multiplier low bit, extra bit}
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    typedef struct packed {
        logic signed [ACC_W-1:0] mc;     // sign-extended multiplicand
        logic signed [ACC_W-1:0] acc;    // partial product, high half
        logic        [WIDTH-1:0] q;      // multiplier, shifted
        logic                    extra;  // Booth extra bit
    } bsm_work_t;

endpackage

### src/bsm_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_stage
// One radix-2 Booth step with its pipeline register and a per-stage ready
// so that bubbles collapse while the output stalls.
// ----------------------------------------------------------------------------
module bsm_stage
    import bsm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bsm_work_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output bsm_work_t out_data
);

    logic                    valid_reg;
    bsm_work_t               data_reg;
    bsm_work_t               data_next;
    logic signed [ACC_W-1:0] sum;

    always_comb
    begin
        case ({in_data.q[0], in_data.extra})
            BOOTH_SUB: sum = in_data.acc - in_data.mc;
            BOOTH_ADD: sum = in_data.acc + in_data.mc;
            default:   sum = in_data.acc;
        endcase
    end

    // arithmetic shift right of {acc, q, extra}
    always_comb
    begin
        data_next.mc    = in_data.mc;
        data_next.acc   = {sum[ACC_W-1], sum[ACC_W-1:1]};
        data_next.q     = {sum[0], in_data.q[WIDTH-1:1]};
        data_next.extra = in_data.q[0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/booth_signed_multiplier.sv
`timescale 1ns / 1ps
// Each operand pair passes through the pipeline stages in order, one Booth step per
// stage, from input transaction to product transaction.
// Throughput: one product per cycle unless m_axis_tready stalls; each of the 32
// stages holds one Booth add/subtract and shift, and stalls fill bubbles stage by stage.
// Reset: rst_n clears all stage valid bits; the data path is not reset.
// ----------------------------------------------------------------------------
// booth_signed_multiplier
// Radix-2 Booth signed multiplier, fully pipelined, stream interfaces.
// ----------------------------------------------------------------------------
module booth_signed_multiplier
    import bsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [31:0] multiplicand, [63:32] multiplier
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PRODUCT_W-1:0] m_axis_tdata    // [63:0] product
);

    logic      valid_w [STAGES+1];
    logic      ready_w [STAGES+1];
    bsm_work_t data_w  [STAGES+1];

    logic [WIDTH-1:0]          mc_in;
    logic signed [2*WIDTH-1:0] prod_full;

    // take low WIDTH bits of each operand, sign-extend the multiplicand
    assign mc_in = s_axis_tdata[WIDTH-1:0];

    always_comb
    begin
        data_w[0].mc    = {mc_in[WIDTH-1], mc_in};
        data_w[0].acc   = '0;
        data_w[0].q     = s_axis_tdata[FIELD_W +: WIDTH];
        data_w[0].extra = 1'b0;
    end

    assign valid_w[0]    = s_axis_tvalid;
    assign s_axis_tready = ready_w[0];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_step
        bsm_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_data   (data_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_data  (data_w[i+1])
        );
    end

    assign ready_w[STAGES] = m_axis_tready;
    assign m_axis_tvalid   = valid_w[STAGES];

    // product is accumulator low half joined to the shifted multiplier
    assign prod_full    = {data_w[STAGES].acc[WIDTH-1:0], data_w[STAGES].q};
    assign m_axis_tdata = PRODUCT_W'(prod_full);

endmodule

### verif/tb_booth_signed_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_booth_signed_multiplier
// Self-checking bench for the pipelined Booth multiplier. Operand pairs go in
// through the slave stream and each product is checked, in order, against a
// bit-accurate Booth recoding computed here. Corner operands come first,
// then random pairs with and without back-pressure, and a full drain in
// between.
// ----------------------------------------------------------------------------
module tb_booth_signed_multiplier;
    import bsm_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0]   mcand;
        logic [FIELD_W-1:0]   mplier;
        logic [PRODUCT_W-1:0] product;
    } product_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;   // [31:0] multiplicand, [63:32] multiplier
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [PRODUCT_W-1:0] m_axis_tdata;   // [63:0] product

    product_entry_t expected_products[$];
    int             mismatches;
    bit             steady_flow;

    booth_signed_multiplier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Radix-2 Booth recoding over WIDTH steps with a 64-bit accumulator
    function automatic logic [PRODUCT_W-1:0] booth_product(input logic [FIELD_W-1:0] mcand,
                                                           input logic [FIELD_W-1:0] mplier);
        logic [63:0]      mc_ext;
        logic [63:0]      acc;
        logic [WIDTH-1:0] q;
        logic             extra;
        mc_ext = {{(64 - WIDTH){mcand[WIDTH-1]}}, mcand[WIDTH-1:0]};
        acc    = '0;
        q      = mplier[WIDTH-1:0];
        extra  = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            case ({q[0], extra})
                BOOTH_SUB: acc = acc - mc_ext;
                BOOTH_ADD: acc = acc + mc_ext;
                default:   ;
            endcase
            extra = q[0];
            q     = {acc[0], q[WIDTH-1:1]};
            acc   = {acc[63], acc[63:1]};
        end
        return (acc << WIDTH) + 64'(q);
    endfunction

    function automatic logic [FIELD_W-1:0] random_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return 32'h8000_0000;
        else if (pick < 8)
            return 32'h7FFF_FFFF;
        else if (pick < 11)
            return 32'hFFFF_FFFF;
        else if (pick < 13)
            return '0;
        else if (pick < 16)
            return (pick[0]) ? 32'h5555_5555 : 32'hAAAA_AAAA;
        else if (pick < 30)
            return 32'($signed(8'($urandom)));
        else
            return $urandom;
    endfunction

    // Entered and left at a falling edge
    task automatic send_operands(input logic [FIELD_W-1:0] mcand,
                                 input logic [FIELD_W-1:0] mplier);
        while (!steady_flow && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mplier, mcand};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (expected_products.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_operand_extremes();
        logic [FIELD_W-1:0] corners [0:4];
        corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000};
        foreach (corners[a])
            foreach (corners[b])
                send_operands(corners[a], corners[b]);
    endtask

    task automatic test_random_operands(input int count);
        for (int i = 0; i < count; i++)
            send_operands(random_operand(), random_operand());
    endtask

    task automatic test_back_to_back(input int count);
        steady_flow = 1'b1;
        test_random_operands(count);
        steady_flow = 1'b0;
    endtask

    task automatic test_drain_and_resume();
        test_random_operands(50);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        wait_for_drain();
        test_random_operands(50);
    endtask

    // Receiver: back-pressure at random unless the flow is held steady
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 6);
        end
    end

    // Record accepted operands and check each product transaction
    always @(posedge clk)
    begin
        product_entry_t entry;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                entry.mcand   = s_axis_tdata[FIELD_W-1:0];
                entry.mplier  = s_axis_tdata[IN_DATA_W-1:FIELD_W];
                entry.product = booth_product(entry.mcand, entry.mplier);
                expected_products.push_back(entry);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_products.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected product %h", $time, m_axis_tdata);
                end
                else
                begin
                    entry = expected_products.pop_front();
                    if (m_axis_tdata !== entry.product)
                    begin
                        mismatches++;
                        $display("%0t: %h * %h expected %h actual %h", $time,
                                 entry.mcand, entry.mplier, entry.product, m_axis_tdata);
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        mismatches    = 0;
        steady_flow   = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_operand_extremes();
        test_random_operands(500);
        test_back_to_back(300);
        test_drain_and_resume();

        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        wait_for_drain();
        // catch any stray product still in the pipe
        repeat (STAGES + 8) @(posedge clk);
        if (mismatches == 0 && expected_products.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
